/* sv/srec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record parser package
// Shared types, codes and character helpers for the S-record parser.
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_4    = 8'h34;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UF   = 8'h46;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LF   = 8'h66;
  localparam logic [7:0] MAX_COUNT_RESET = 8'hFF;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CSUM  = 3'd4,
    PH_EOL   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DATA  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TYPE  = 2'd1,
    ERR_COUNT = 2'd2
  } err_kind_t;

  typedef struct packed {
    logic        digits_ok;
    logic        checksum_ok;
    logic [7:0]  data_index;
    logic [7:0]  data_byte;
    logic [31:0] load_address;
    logic [7:0]  byte_count;
    logic [3:0]  record_type;
    err_kind_t   error_kind;
    status_t     status;
  } result_t;

  // Upper bit flags a hex digit, the low nibble is its value (zero otherwise).
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      v = c - CHAR_0;
      return {1'b1, v[3:0]};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      v = c - CHAR_UA + 8'd10;
      return {1'b1, v[3:0]};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      v = c - CHAR_LA + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // Address length in bytes for each record type.
  function automatic logic [2:0] addr_bytes(input logic [3:0] t);
    case (t)
      4'd2, 4'd6, 4'd8: return 3'd3;
      4'd3, 4'd7:       return 3'd4;
      4'd4:             return 3'd0;
      default:          return 3'd2;
    endcase
  endfunction

endpackage
`default_nettype wire

/* sv/srec_record_stream_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record stream parser
// Parses an ASCII S-record stream one character a beat, giving one result
// beat per character: busy, data byte, record complete or error.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata[7:0] = in_char
//  m_*       out        tuser[1:0] = status; tdata = error_kind, record_type,
//                       byte_count, load_address, data_byte, data_index,
//                       checksum_ok, digits_ok (lowest bits first)
//  max_count in         write enable and 8-bit value of the byte count limit
//
// The parse step handles one character per beat, so one beat can be
// accepted every cycle while the output is not stalled. A character passes
// through the input register and then the result register to the output.
// Reset clears the record state, both valid flags and sets max_count to 255.
// A stall on the output holds the result register and, once the input
// register is also full, deasserts s_tready; no beat is dropped or repeated.
//
module srec_record_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Character input: in_char[7:0].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // Result output.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // error_kind[1:0], record_type[5:2], byte_count[13:6], load_address[45:14],
  // data_byte[53:46], data_index[61:54], checksum_ok[62], digits_ok[63].
  output logic [63:0]      m_tdata,
  // status[1:0].
  output logic [1:0]       m_tuser,
  // Byte count limit register.
  input  wire logic        max_count_we,
  input  wire logic [7:0]  max_count_data
);
  import srec_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       load_ok;
  logic       fire;
  logic [7:0] max_count;
  result_t    result;
  result_t    held;

  // The parse step advances when a character is waiting and the result
  // register is free or being emptied in this same cycle.
  assign fire = in_valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (max_count_we) begin
      max_count <= max_count_data;
    end
  end

  srec_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .fire     (fire),
    .in_valid (in_valid),
    .in_char  (in_char)
  );

  srec_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_char   (in_char),
    .max_count (max_count),
    .result    (result)
  );

  srec_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .result   (result),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (held)
  );

  // Status travels on tuser; the remaining fields pack into tdata.
  assign m_tuser = held.status;
  assign m_tdata = {held.digits_ok, held.checksum_ok, held.data_index, held.data_byte,
                    held.load_address, held.byte_count, held.record_type, held.error_kind};

endmodule
`default_nettype wire

/* sv/srec_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record input stage
// Registers one incoming character beat and holds it until the parser fires.
// ----------------------------------------------------------------------------
module srec_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       fire,
  output logic            in_valid,
  output logic [7:0]      in_char
);
  import srec_pkg::*;

  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

endmodule
`default_nettype wire

/* sv/srec_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record parse step
// Record state and the per-character next-state and result logic.
// ----------------------------------------------------------------------------
module srec_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       in_char,
  input  wire logic [7:0]       max_count,
  output srec_pkg::result_t     result
);
  import srec_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  char_count, char_count_next;
  logic [7:0]  first_char, first_char_next;
  logic [3:0]  type_reg, type_reg_next;
  logic [7:0]  count_reg, count_reg_next;
  logic [31:0] address_reg, address_reg_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  data_counter, data_counter_next;
  logic        digit_flag, digit_flag_next;
  logic        sum_good, sum_good_next;

  logic        restart;
  logic [4:0]  hex;
  logic [2:0]  alen;
  logic [7:0]  alen_plus1;
  logic [7:0]  pair_byte;
  logic        pair_done;
  logic [7:0]  type_char;
  logic        type_ok;
  logic [3:0]  type_val;
  logic [7:0]  type_wide;
  logic [3:0]  addr_cnt;

  assign hex        = hex_nibble(in_char);
  assign alen       = addr_bytes(type_reg);
  assign alen_plus1 = {5'd0, alen} + 8'd1;
  assign pair_byte  = {high_nibble, hex[3:0]};
  assign pair_done  = char_count[0];
  assign addr_cnt   = char_count + 4'd1;

  // Type field: 'S' and a digit in either order, any digit but 4.
  always_comb begin
    type_char = 8'd0;
    type_ok   = 1'b0;
    if (first_char == CHAR_S) begin
      type_char = in_char;
      type_ok   = 1'b1;
    end else if (in_char == CHAR_S) begin
      type_char = first_char;
      type_ok   = 1'b1;
    end
    if (type_char < CHAR_0 || type_char > CHAR_9 || type_char == CHAR_4) begin
      type_ok = 1'b0;
    end
    type_wide = type_char - CHAR_0;
    type_val  = type_wide[3:0];
  end

  always_comb begin
    phase_next        = phase;
    char_count_next   = char_count;
    first_char_next   = first_char;
    type_reg_next     = type_reg;
    count_reg_next    = count_reg;
    address_reg_next  = address_reg;
    high_nibble_next  = high_nibble;
    running_sum_next  = running_sum;
    data_counter_next = data_counter;
    digit_flag_next   = digit_flag;
    sum_good_next     = sum_good;
    restart           = 1'b0;
    result            = '0;
    result.status     = ST_BUSY;
    result.error_kind = ERR_NONE;

    // Hex fields share the digit check; count, data and checksum also share the nibble pairing.
    if (phase == PH_COUNT || phase == PH_DATA || phase == PH_CSUM || phase == PH_ADDR) begin
      if (!hex[4]) begin
        digit_flag_next = 1'b0;
      end
    end
    if (phase == PH_COUNT || phase == PH_DATA || phase == PH_CSUM) begin
      if (!pair_done) begin
        high_nibble_next = hex[3:0];
        char_count_next  = 4'd1;
      end else begin
        char_count_next  = 4'd0;
      end
    end

    case (phase)
      PH_TYPE: begin
        if (char_count == 4'd0) begin
          first_char_next = in_char;
          char_count_next = 4'd1;
        end else if (!type_ok) begin
          result.status     = ST_ERROR;
          result.error_kind = ERR_TYPE;
          restart           = 1'b1;
        end else begin
          type_reg_next   = type_val;
          phase_next      = PH_COUNT;
          char_count_next = 4'd0;
        end
      end
      PH_COUNT: begin
        if (pair_done) begin
          count_reg_next   = pair_byte;
          running_sum_next = running_sum + pair_byte;
          if (pair_byte == 8'd0 || pair_byte > max_count || pair_byte < alen_plus1) begin
            result.status     = ST_ERROR;
            result.error_kind = ERR_COUNT;
            restart           = 1'b1;
          end else begin
            phase_next = PH_ADDR;
          end
        end
      end
      PH_ADDR: begin
        address_reg_next = {address_reg[27:0], hex[3:0]};
        char_count_next  = addr_cnt;
        if (!addr_cnt[0]) begin
          running_sum_next = running_sum + {address_reg[3:0], hex[3:0]};
        end
        if (addr_cnt >= {alen, 1'b0}) begin
          char_count_next = 4'd0;
          phase_next      = (count_reg > alen_plus1) ? PH_DATA : PH_CSUM;
        end
      end
      PH_DATA: begin
        if (pair_done) begin
          result.status     = ST_DATA;
          result.data_byte  = pair_byte;
          result.data_index = data_counter;
          running_sum_next  = running_sum + pair_byte;
          data_counter_next = data_counter + 8'd1;
          if (data_counter_next >= count_reg - alen_plus1) begin
            phase_next = PH_CSUM;
          end
        end
      end
      PH_CSUM: begin
        if (pair_done) begin
          sum_good_next = (~running_sum == pair_byte);
          phase_next    = PH_EOL;
        end
      end
      PH_EOL: begin
        char_count_next = char_count + 4'd1;
        if (char_count_next >= 4'd2) begin
          result.status      = ST_DONE;
          result.checksum_ok = sum_good;
          restart            = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // A restart result still shows the fields as they stood before clearing.
    result.record_type  = type_reg_next;
    result.byte_count   = count_reg_next;
    result.load_address = address_reg_next;
    result.digits_ok    = digit_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && restart)) begin
      phase        <= PH_TYPE;
      char_count   <= 4'd0;
      first_char   <= 8'd0;
      type_reg     <= 4'd0;
      count_reg    <= 8'd0;
      address_reg  <= 32'd0;
      high_nibble  <= 4'd0;
      running_sum  <= 8'd0;
      data_counter <= 8'd0;
      digit_flag   <= 1'b1;
      sum_good     <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      char_count   <= char_count_next;
      first_char   <= first_char_next;
      type_reg     <= type_reg_next;
      count_reg    <= count_reg_next;
      address_reg  <= address_reg_next;
      high_nibble  <= high_nibble_next;
      running_sum  <= running_sum_next;
      data_counter <= data_counter_next;
      digit_flag   <= digit_flag_next;
      sum_good     <= sum_good_next;
    end
  end

endmodule
`default_nettype wire

/* sv/srec_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record output stage
// Result register; holds a beat while the consumer stalls.
// ----------------------------------------------------------------------------
module srec_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire srec_pkg::result_t result,
  output logic                   load_ok,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output srec_pkg::result_t      held
);
  import srec_pkg::*;

  assign load_ok = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_ok) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      held <= result;
    end
  end

endmodule
`default_nettype wire

/* sv/srec_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-record parser port checker
// Watches the top-level ports and checks result beats for consistency.
// ----------------------------------------------------------------------------
module srec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import srec_pkg::*;

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // No result beat directly after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // An error beat names its kind; other beats carry none.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ERROR |-> m_tdata[1:0] != ERR_NONE)
    else $error("error beat without error kind");

  a_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_ERROR |-> m_tdata[1:0] == ERR_NONE)
    else $error("error kind on a non-error beat");

  // A good checksum is only ever reported with a completed record.
  a_checksum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[62] |-> m_tuser == ST_DONE)
    else $error("checksum flag outside record completion");

endmodule

bind srec_record_stream_parser_core srec_checker u_srec_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
